### hw/rtl/overlapping_frame_buffer_assert.svh
// Assertion macros used by the overlapping frame buffer port checker.
`ifndef OVERLAPPING_FRAME_BUFFER_ASSERT_SVH
`define OVERLAPPING_FRAME_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define OFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("overlapping_frame_buffer: check failed");

// Next-cycle implication, disabled while reset is held.
`define OFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("overlapping_frame_buffer: check failed");

`endif

### hw/rtl/ofb_pkg.sv
// Shared types and constants of the overlapping frame buffer.
package ofb_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int LEN_BITS     = 7;
    localparam int POS_BITS     = 6;
    localparam int HOP_CNT_BITS = 8;
    localparam int INDEX_BITS   = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 7;

    // Output queue in the merging stage.
    localparam int MRG_DEPTH    = 4;
    localparam int MRG_PTR_BITS = 2;
    localparam int MRG_LVL_BITS = 3;

    localparam logic [LEN_BITS-1:0] PEND_MAX = 7'h7F;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_LENGTH = 1'b0,
        REG_HOP_LENGTH   = 1'b1
    } t_cfg_reg;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Sideband that travels with each ring read.
    typedef struct packed {
        logic                valid;
        logic [POS_BITS-1:0] pos;
        logic                last;
        logic                pad;
        logic                flush;
    } t_rd_tag;

    typedef struct packed {
        logic [MRG_LVL_BITS-1:0] level;
    } t_mrg_status;

    typedef struct packed {
        logic [POS_BITS-1:0]   frame_position;
        t_sample               frame_ch0;
        t_sample               frame_ch1;
        logic                  last_in_frame;
        logic                  final_frame;
        logic [INDEX_BITS-1:0] play_index;
    } t_frame;

endpackage

### hw/rtl/ofb_smp_if.sv
// Sample input channel of the overlapping frame buffer.
interface ofb_smp_if;
    logic             valid;
    logic             ready;
    logic             operation;
    ofb_pkg::t_sample sample_ch0;
    ofb_pkg::t_sample sample_ch1;

    modport source (output valid, output operation, output sample_ch0, output sample_ch1,
                    input ready);
    modport sink (input valid, input operation, input sample_ch0, input sample_ch1,
                  output ready);
endinterface

### hw/rtl/ofb_frm_if.sv
// Frame result channel of the overlapping frame buffer.
interface ofb_frm_if;
    logic                              valid;
    logic                              ready;
    logic [ofb_pkg::POS_BITS-1:0]      frame_position;
    ofb_pkg::t_sample                  frame_ch0;
    ofb_pkg::t_sample                  frame_ch1;
    logic                              last_in_frame;
    logic                              final_frame;
    logic [ofb_pkg::INDEX_BITS-1:0]    play_index;

    modport source (output valid, output frame_position, output frame_ch0,
                    output frame_ch1, output last_in_frame, output final_frame,
                    output play_index, input ready);
    modport sink (input valid, input frame_position, input frame_ch0, input frame_ch1,
                  input last_in_frame, input final_frame, input play_index,
                  output ready);
endinterface

### hw/rtl/overlapping_frame_buffer.sv
// Top level of the overlapping frame buffer: sequencer, channel lanes and merge.
//
// Samples arrive on i_smp, one pair per transfer; operation selects a push or a
// finish. Each push is stored in a per-channel ring of MAX_FRAME entries. Once
// frame_length pushes have arrived, and after that every hop_length pushes, the
// push that completes a hop produces a frame of frame_length results on o_frm,
// oldest sample first, with last_in_frame on its final result. A finish with
// samples pending produces one zero-padded frame flagged by final_frame. Write
// registers on the i_cfg_* port only while idle: the block does not enforce it.
//
// A push or finish that produces nothing leaves the block idle and ready. One
// that produces a frame holds i_smp.ready low while the sequencer issues
// frame_length ring reads, one per cycle while the output queue has room;
// each read passes through the lane read register into the output queue. The
// ring read port and the four-entry output queue set that rate.
// When the receiver stalls, the queue fills and reads pause; nothing is lost.
// Synchronous reset restores frame_length 64 and hop_length 32, re-arms the hop
// count and clears the rest; the ring is kept, as no unwritten slot is output.
module overlapping_frame_buffer #(
    parameter int MAX_FRAME   = 64,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ofb_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [ofb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    ofb_smp_if.sink                             i_smp,
    ofb_frm_if.source                           o_frm
);

    localparam int AW         = $clog2(MAX_FRAME);
    localparam int STORE_BITS = (SAMPLE_BITS < ofb_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                  : ofb_pkg::SAMPLE_W;

    logic                                wr_en, rd_en;
    logic [AW-1:0]                       wr_addr, rd_addr;
    ofb_pkg::t_rd_tag                    tag;
    ofb_pkg::t_mrg_status                mrg_status;
    logic [ofb_pkg::INDEX_BITS-1:0]      play_index;
    logic [1:0][ofb_pkg::SAMPLE_W-1:0]   smp_all;
    logic [CHANNELS-1:0][STORE_BITS-1:0] lane_data;

    assign smp_all = {i_smp.sample_ch1, i_smp.sample_ch0};

    ofb_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_smp.valid),
        .i_operation  (i_smp.operation),
        .o_in_ready   (i_smp.ready),
        .i_mrg        (mrg_status),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_tag        (tag),
        .o_play_index (play_index)
    );

    generate
        for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
            ofb_lane #(
                .DEPTH (MAX_FRAME),
                .WIDTH (STORE_BITS)
            ) u_lane (
                .i_clk     (i_clk),
                .i_wr_en   (wr_en),
                .i_wr_addr (wr_addr),
                .i_wr_data (smp_all[c][STORE_BITS-1:0]),
                .i_rd_en   (rd_en),
                .i_rd_addr (rd_addr),
                .o_rd_data (lane_data[c])
            );
        end
    endgenerate

    ofb_merge #(
        .CHANNELS   (CHANNELS),
        .STORE_BITS (STORE_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (tag),
        .i_play_index (play_index),
        .i_lane_data  (lane_data),
        .o_status     (mrg_status),
        .o_frm        (o_frm)
    );

endmodule

### hw/rtl/ofb_lane.sv
// One channel lane: ring memory with one write port and a registered read port.
module ofb_lane #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ofb_ctrl.sv
// Frame sequencer: counters, hop tracking and ring read issue for all lanes.
module ofb_ctrl #(
    parameter int MAX_FRAME = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ofb_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ofb_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_operation,
    output logic                                 o_in_ready,
    input  ofb_pkg::t_mrg_status                 i_mrg,
    output logic                                 o_wr_en,
    output logic [$clog2(MAX_FRAME)-1:0]         o_wr_addr,
    output logic                                 o_rd_en,
    output logic [$clog2(MAX_FRAME)-1:0]         o_rd_addr,
    output ofb_pkg::t_rd_tag                     o_tag,
    output logic [ofb_pkg::INDEX_BITS-1:0]       o_play_index
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int SW = AW + 1;
    localparam logic [ofb_pkg::LEN_BITS-1:0] MAX_LEN = ofb_pkg::LEN_BITS'(MAX_FRAME);
    localparam logic [SW-1:0] MAX_SLOT  = SW'(MAX_FRAME);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_FRAME - 1);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    function automatic logic [ofb_pkg::LEN_BITS-1:0] eff_len(
        input logic [ofb_pkg::LEN_BITS-1:0] v,
        input logic [ofb_pkg::LEN_BITS-1:0] hi
    );
        logic [ofb_pkg::LEN_BITS-1:0] res;
        if (v == '0) begin
            res = ofb_pkg::LEN_BITS'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : AW'(s + AW'(1));
    endfunction

    t_state                                   r_state, n_state;
    logic [ofb_pkg::LEN_BITS-1:0]             r_frame_len, n_frame_len;
    logic [ofb_pkg::LEN_BITS-1:0]             r_hop_len, n_hop_len;
    logic [AW-1:0]                            r_wp, n_wp;
    logic signed [ofb_pkg::HOP_CNT_BITS-1:0]  r_hop_cnt, n_hop_cnt;
    logic [ofb_pkg::LEN_BITS-1:0]             r_pending, n_pending;
    logic [ofb_pkg::INDEX_BITS-1:0]           r_samples, n_samples;
    logic [ofb_pkg::POS_BITS-1:0]             r_pos, n_pos;
    logic [ofb_pkg::LEN_BITS-1:0]             r_fill, n_fill;
    logic                                     r_flush, n_flush;
    logic [AW-1:0]                            r_slot, n_slot;
    ofb_pkg::t_rd_tag                         r_tag, n_tag;

    logic [ofb_pkg::LEN_BITS-1:0]             cur_f, cur_h, new_f, new_h;
    logic signed [ofb_pkg::HOP_CNT_BITS-1:0]  rearm_cnt, hc_inc;
    logic [ofb_pkg::LEN_BITS-1:0]             pend_inc, fill_start;
    logic                                     accept, push, finish, hit, start;
    logic                                     credit, issue, pos_last;
    logic [AW-1:0]                            wp_inc, wp_base;
    logic [SW-1:0]                            slot_sum, slot_start;

    always_comb begin
        n_frame_len = r_frame_len;
        n_hop_len   = r_hop_len;
        if (i_cfg_we) begin
            unique case (ofb_pkg::t_cfg_reg'(i_cfg_index))
                ofb_pkg::REG_FRAME_LENGTH: n_frame_len = i_cfg_data;
                ofb_pkg::REG_HOP_LENGTH:   n_hop_len   = i_cfg_data;
            endcase
        end
    end

    assign cur_f     = eff_len(r_frame_len, MAX_LEN);
    assign cur_h     = eff_len(r_hop_len, cur_f);
    assign new_f     = eff_len(n_frame_len, MAX_LEN);
    assign new_h     = eff_len(n_hop_len, new_f);
    assign rearm_cnt = $signed({1'b0, new_h}) - $signed({1'b0, new_f});

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign push       = accept && (i_operation == ofb_pkg::OP_PUSH);
    assign finish     = accept && (i_operation == ofb_pkg::OP_FINISH);

    assign pend_inc = (r_pending == ofb_pkg::PEND_MAX) ? r_pending
                                                       : r_pending + 1'b1;
    assign hc_inc   = r_hop_cnt + 8'sd1;
    assign hit      = push && (hc_inc >= $signed({1'b0, cur_h}));
    assign start    = hit || (finish && (r_pending != '0));
    assign wp_inc   = slot_inc(r_wp);

    // A frame of n samples starts n slots behind the write pointer.
    assign fill_start = hit ? cur_f : ((r_pending < cur_f) ? r_pending : cur_f);
    assign wp_base    = hit ? wp_inc : r_wp;
    assign slot_sum   = {1'b0, wp_base} + MAX_SLOT - SW'(fill_start);
    assign slot_start = (slot_sum >= MAX_SLOT) ? slot_sum - MAX_SLOT : slot_sum;

    // Keep the merge queue from overflowing, counting the read still in flight.
    assign credit   = (ofb_pkg::MRG_LVL_BITS'(i_mrg.level)
                       + ofb_pkg::MRG_LVL_BITS'(r_tag.valid))
                      < ofb_pkg::MRG_LVL_BITS'(ofb_pkg::MRG_DEPTH);
    assign issue    = (r_state == ST_EMIT) && credit;
    assign pos_last = (({1'b0, r_pos} + 1'b1) == cur_f);

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_hop_cnt = r_hop_cnt;
        n_pending = r_pending;
        n_samples = r_samples;
        n_pos     = r_pos;
        n_fill    = r_fill;
        n_flush   = r_flush;
        n_slot    = r_slot;
        n_tag     = r_tag;
        n_tag.valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (push) begin
                    n_wp      = wp_inc;
                    n_samples = r_samples + 1'b1;
                    n_pending = pend_inc;
                    n_hop_cnt = hc_inc;
                    if (hit) begin
                        n_hop_cnt = '0;
                        n_pending = (pend_inc >= cur_h) ? pend_inc - cur_h : '0;
                    end
                end
                if (start) begin
                    n_state = ST_EMIT;
                    n_pos   = '0;
                    n_fill  = fill_start;
                    n_flush = finish;
                    n_slot  = AW'(slot_start);
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    n_tag.valid = 1'b1;
                    n_tag.pos   = r_pos;
                    n_tag.last  = pos_last;
                    n_tag.pad   = ({1'b0, r_pos} >= r_fill);
                    n_tag.flush = r_flush;
                    n_pos       = r_pos + 1'b1;
                    n_slot      = slot_inc(r_slot);
                    if (pos_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase

        if (i_cfg_we) begin
            n_hop_cnt = rearm_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frame_len <= ofb_pkg::LEN_BITS'(64);
            r_hop_len   <= ofb_pkg::LEN_BITS'(32);
            r_wp        <= '0;
            r_hop_cnt   <= $signed({1'b0, eff_len(ofb_pkg::LEN_BITS'(32),
                                   eff_len(ofb_pkg::LEN_BITS'(64), MAX_LEN))})
                           - $signed({1'b0, eff_len(ofb_pkg::LEN_BITS'(64), MAX_LEN)});
            r_pending   <= '0;
            r_samples   <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_flush     <= 1'b0;
            r_slot      <= '0;
            r_tag       <= '0;
        end else begin
            r_state     <= n_state;
            r_frame_len <= n_frame_len;
            r_hop_len   <= n_hop_len;
            r_wp        <= n_wp;
            r_hop_cnt   <= n_hop_cnt;
            r_pending   <= n_pending;
            r_samples   <= n_samples;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_flush     <= n_flush;
            r_slot      <= n_slot;
            r_tag       <= n_tag;
        end
    end

    assign o_wr_en      = push;
    assign o_wr_addr    = r_wp;
    assign o_rd_en      = issue;
    assign o_rd_addr    = r_slot;
    assign o_tag        = r_tag;
    assign o_play_index = r_samples;

endmodule

### hw/rtl/ofb_merge.sv
// Merging stage: joins lane read data with its sideband and queues the results.
module ofb_merge #(
    parameter int CHANNELS   = 2,
    parameter int STORE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ofb_pkg::t_rd_tag                       i_tag,
    input  logic [ofb_pkg::INDEX_BITS-1:0]         i_play_index,
    input  logic [CHANNELS-1:0][STORE_BITS-1:0]    i_lane_data,
    output ofb_pkg::t_mrg_status                   o_status,
    ofb_frm_if.source                              o_frm
);

    ofb_pkg::t_frame                     r_buf [ofb_pkg::MRG_DEPTH];
    logic [ofb_pkg::MRG_PTR_BITS-1:0]    r_head, r_tail;
    logic [ofb_pkg::MRG_LVL_BITS-1:0]    r_level;
    ofb_pkg::t_frame                     entry, head;
    ofb_pkg::t_sample                    ch1_val;
    logic                                pop;

    // Padding positions of a flush frame read as zero on every channel.
    generate
        if (CHANNELS >= 2) begin : g_ch1
            assign ch1_val = i_tag.pad ? '0 : ofb_pkg::SAMPLE_W'(i_lane_data[1]);
        end else begin : g_no_ch1
            assign ch1_val = '0;
        end
    endgenerate

    always_comb begin
        entry.frame_position = i_tag.pos;
        entry.frame_ch0      = i_tag.pad ? '0 : ofb_pkg::SAMPLE_W'(i_lane_data[0]);
        entry.frame_ch1      = ch1_val;
        entry.last_in_frame  = i_tag.last;
        entry.final_frame    = i_tag.flush;
        entry.play_index     = i_play_index;
    end

    assign pop = o_frm.valid && o_frm.ready;

    always_ff @(posedge i_clk) begin
        if (i_tag.valid) begin
            r_buf[r_tail] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            if (i_tag.valid) begin
                r_tail <= r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            r_level <= r_level + ofb_pkg::MRG_LVL_BITS'(i_tag.valid)
                       - ofb_pkg::MRG_LVL_BITS'(pop);
        end
    end

    assign head                 = r_buf[r_head];
    assign o_frm.valid          = (r_level != '0);
    assign o_frm.frame_position = head.frame_position;
    assign o_frm.frame_ch0      = head.frame_ch0;
    assign o_frm.frame_ch1      = head.frame_ch1;
    assign o_frm.last_in_frame  = head.last_in_frame;
    assign o_frm.final_frame    = head.final_frame;
    assign o_frm.play_index     = head.play_index;
    assign o_status.level       = r_level;

endmodule

### hw/rtl/ofb_checker.sv
// Port-level checks of the overlapping frame buffer, bound to the top level.
`include "overlapping_frame_buffer_assert.svh"

module ofb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [ofb_pkg::POS_BITS-1:0]      i_pos,
    input  ofb_pkg::t_sample                  i_ch0,
    input  ofb_pkg::t_sample                  i_ch1,
    input  logic                              i_last,
    input  logic                              i_final,
    input  logic [ofb_pkg::INDEX_BITS-1:0]    i_play_index
);

    logic                              r_mid;
    logic [ofb_pkg::POS_BITS-1:0]      r_exp_pos;
    logic                              r_final;
    logic [ofb_pkg::INDEX_BITS-1:0]    r_pi;
    logic                              xfer;

    assign xfer = i_out_valid && i_out_ready;

    // Track where the current frame stands from the transfers seen so far.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_exp_pos <= '0;
            r_final   <= 1'b0;
            r_pi      <= '0;
        end else if (xfer) begin
            r_mid     <= !i_last;
            r_exp_pos <= i_last ? '0 : i_pos + 1'b1;
            r_final   <= i_final;
            r_pi      <= i_play_index;
        end
    end

    `OFB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_pos, i_ch0, i_ch1, i_last, i_final, i_play_index}))
    `OFB_ASSERT_IMPL(a_position_order, i_clk, i_rst_n, i_out_valid, i_pos == r_exp_pos)
    `OFB_ASSERT_IMPL(a_final_steady, i_clk, i_rst_n, i_out_valid && r_mid, i_final == r_final)
    `OFB_ASSERT_IMPL(a_index_steady, i_clk, i_rst_n, i_out_valid && r_mid, i_play_index == r_pi)

endmodule

bind overlapping_frame_buffer ofb_checker u_ofb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_frm.valid),
    .i_out_ready  (o_frm.ready),
    .i_pos        (o_frm.frame_position),
    .i_ch0        (o_frm.frame_ch0),
    .i_ch1        (o_frm.frame_ch1),
    .i_last       (o_frm.last_in_frame),
    .i_final      (o_frm.final_frame),
    .i_play_index (o_frm.play_index)
);

### sim/overlapping_frame_buffer_checker.sv
// Checker that predicts every frame result of the overlapping frame buffer and compares it.
`timescale 1ns / 1ps
module overlapping_frame_buffer_checker
    import ofb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    ofb_smp_if                       i_smp,
    ofb_frm_if                       i_frm,
    output int                       o_errors,
    output int                       o_outstanding,
    output int                       o_results,
    output int                       o_frames
);

    localparam int RING_DEPTH = 64;

    logic [LEN_BITS-1:0]   frame_len_reg;
    logic [LEN_BITS-1:0]   hop_len_reg;
    t_sample               ring_ch0 [RING_DEPTH];
    t_sample               ring_ch1 [RING_DEPTH];
    logic [POS_BITS-1:0]   wr_slot;
    int                    hop_count;
    int                    pend_count;
    logic [INDEX_BITS-1:0] push_count;
    t_frame                frame_results_due [$];
    int                    errors = 0;
    int                    results = 0;
    int                    frames = 0;

    function automatic int eff_frame_len();
        if (frame_len_reg == 0) return 1;
        if (int'(frame_len_reg) > RING_DEPTH) return RING_DEPTH;
        return int'(frame_len_reg);
    endfunction

    function automatic int eff_hop_len();
        int f;
        f = eff_frame_len();
        if (hop_len_reg == 0) return 1;
        if (int'(hop_len_reg) > f) return f;
        return int'(hop_len_reg);
    endfunction

    task automatic rearm_hop();
        hop_count = eff_hop_len() - eff_frame_len();
    endtask

    // Queues one frame of f results; the first n positions carry the newest n samples.
    task automatic queue_frame(input int f, input int n, input bit flush);
        t_frame              r;
        logic [POS_BITS-1:0] slot;
        for (int i = 0; i < f; i++) begin
            r.frame_position = POS_BITS'(i);
            r.frame_ch0      = '0;
            r.frame_ch1      = '0;
            if (i < n) begin
                slot        = wr_slot - POS_BITS'(n - i);
                r.frame_ch0 = ring_ch0[slot];
                r.frame_ch1 = ring_ch1[slot];
            end
            r.last_in_frame = (i == f - 1);
            r.final_frame   = flush;
            r.play_index    = push_count;
            frame_results_due.push_back(r);
        end
    endtask

    task automatic advance_framer(input logic op, input t_sample s0, input t_sample s1);
        int f;
        int h;
        f = eff_frame_len();
        h = eff_hop_len();
        if (op == OP_FINISH) begin
            // A flush leaves the pending count alone, so a second finish repeats it.
            if (pend_count != 0) begin
                queue_frame(f, (pend_count < f) ? pend_count : f, 1'b1);
            end
        end else begin
            ring_ch0[wr_slot] = s0;
            ring_ch1[wr_slot] = s1;
            wr_slot++;
            if (pend_count < int'(PEND_MAX)) pend_count++;
            hop_count++;
            push_count++;
            if (hop_count >= h) begin
                hop_count  = 0;
                pend_count = (pend_count >= h) ? pend_count - h : 0;
                queue_frame(f, f, 1'b0);
            end
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
    endtask

    task automatic check_result();
        t_frame want;
        if (frame_results_due.size() == 0) begin
            $display("%0t: frame result with none expected: position %0d, ch0 %h, ch1 %h",
                     $time, i_frm.frame_position, i_frm.frame_ch0, i_frm.frame_ch1);
            errors++;
        end else begin
            want = frame_results_due.pop_front();
            results++;
            if (want.last_in_frame) frames++;
            if (i_frm.frame_position !== want.frame_position)
                report_field("frame_position", want.frame_position, i_frm.frame_position);
            if (i_frm.frame_ch0 !== want.frame_ch0)
                report_field("frame_ch0", 16'(want.frame_ch0), 16'(i_frm.frame_ch0));
            if (i_frm.frame_ch1 !== want.frame_ch1)
                report_field("frame_ch1", 16'(want.frame_ch1), 16'(i_frm.frame_ch1));
            if (i_frm.last_in_frame !== want.last_in_frame)
                report_field("last_in_frame", want.last_in_frame, i_frm.last_in_frame);
            if (i_frm.final_frame !== want.final_frame)
                report_field("final_frame", want.final_frame, i_frm.final_frame);
            if (i_frm.play_index !== want.play_index)
                report_field("play_index", want.play_index, i_frm.play_index);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len_reg = 7'd64;
            hop_len_reg   = 7'd32;
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_ch0[i] = '0;
                ring_ch1[i] = '0;
            end
            wr_slot    = '0;
            pend_count = 0;
            push_count = '0;
            frame_results_due.delete();
            rearm_hop();
        end else begin
            // Outputs first, so a result can never be matched against a prediction
            // made at the same edge.
            if (i_frm.valid && i_frm.ready) check_result();
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_LENGTH) begin
                    frame_len_reg = i_cfg_data;
                end else begin
                    hop_len_reg = i_cfg_data;
                end
                rearm_hop();
            end
            if (i_smp.valid && i_smp.ready) begin
                advance_framer(i_smp.operation, i_smp.sample_ch0, i_smp.sample_ch1);
            end
        end
        o_outstanding <= frame_results_due.size();
        o_errors      <= errors;
        o_results     <= results;
        o_frames      <= frames;
    end

endmodule

### sim/overlapping_frame_buffer_tb.sv
// Testbench top of the overlapping frame buffer: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module overlapping_frame_buffer_tb;
    import ofb_pkg::*;

    localparam int      LIMIT       = 1_500_000;
    localparam int      HOLD_CYCLES = 400;
    localparam int      ITEM_TARGET = 270;
    localparam int      SETTLE      = 8;
    localparam int      TAIL        = 140;
    localparam t_sample SMP_MIN     = 16'sh8000;
    localparam t_sample SMP_MAX     = 16'sh7FFF;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    ofb_smp_if smp ();
    ofb_frm_if frm ();

    int errors;
    int outstanding;
    int results;
    int frames;
    int items_sent    = 0;
    int pushes_sent   = 0;
    int finishes_sent = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    bit tx_gaps       = 1'b1;
    bit rx_gaps       = 1'b1;
    bit hold_off_req  = 1'b0;

    overlapping_frame_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_smp       (smp),
        .o_frm       (frm)
    );

    overlapping_frame_buffer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_smp         (smp),
        .i_frm         (frm),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_frames      (frames)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not complete within %0d cycles", $time, LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 11))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            2:       return '0;
            3:       return '1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic op, input t_sample s0, input t_sample s1);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid      <= 1'b1;
        smp.operation  <= op;
        smp.sample_ch0 <= s0;
        smp.sample_ch1 <= s1;
        do @(posedge i_clk); while (!smp.ready);
        items_sent++;
        if (op == OP_PUSH) pushes_sent++;
        else finishes_sent++;
    endtask

    task automatic push_random();
        send_item(OP_PUSH, rand_sample(), rand_sample());
    endtask

    // Drops valid and waits until every predicted result has been transferred,
    // then waits out the SETTLE delay for an item that produced nothing.
    task automatic settle();
        smp.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] flen,
                             input logic [CFG_DATA_BITS-1:0] hlen,
                             input bit wr_frame, input bit wr_hop);
        if (wr_frame) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_FRAME_LENGTH;
            cfg_data  <= flen;
            @(posedge i_clk);
        end
        if (wr_hop) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_HOP_LENGTH;
            cfg_data  <= hlen;
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Receiver: a random stall before each transfer, and one long hold-off on request.
    initial begin
        int stall;
        frm.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                frm.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = rx_gaps ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                frm.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            frm.ready <= 1'b1;
            do @(posedge i_clk); while (!frm.valid);
        end
    end

    initial begin
        int                       burst;
        int                       wr_sel;
        logic [CFG_DATA_BITS-1:0] flen;
        logic [CFG_DATA_BITS-1:0] hlen;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_FRAME_LENGTH;
        cfg_data       = '0;
        smp.valid      = 1'b0;
        smp.operation  = OP_PUSH;
        smp.sample_ch0 = '0;
        smp.sample_ch1 = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a finish with nothing pending, then a mostly padded flush,
        // repeated to show the pending count survives it.
        send_item(OP_FINISH, SMP_MAX, SMP_MIN);
        send_item(OP_PUSH, SMP_MIN, SMP_MAX);
        send_item(OP_PUSH, SMP_MAX, SMP_MIN);
        send_item(OP_FINISH, '0, '0);
        send_item(OP_FINISH, '1, '1);
        settle();

        configure(7'd4, 7'd2, 1'b1, 1'b1);
        send_item(OP_PUSH, 16'sh5555, 16'shAAAA);
        send_item(OP_PUSH, 16'shAAAA, 16'sh5555);
        send_item(OP_PUSH, '0, '1);
        send_item(OP_PUSH, '1, '0);
        push_random();
        push_random();
        send_item(OP_FINISH, '0, '0);
        settle();

        // One-sample frames on every push.
        configure(7'd1, 7'd1, 1'b1, 1'b1);
        push_random();
        push_random();
        settle();

        // Zero in both registers clamps to one.
        configure(7'd0, 7'd0, 1'b1, 1'b1);
        push_random();
        settle();

        // Values above the ring depth clamp to a full-length frame.
        configure(7'd127, 7'd100, 1'b1, 1'b1);
        send_item(OP_FINISH, '0, '0);
        settle();

        // A hop longer than the frame is cut to the frame length.
        configure(7'd5, 7'd9, 1'b1, 1'b1);
        repeat (5) push_random();
        send_item(OP_FINISH, '0, '0);
        settle();

        // Re-arming before a frame comes due lets the pending count run into its ceiling.
        configure(7'd64, 7'd1, 1'b1, 1'b1);
        repeat (63) push_random();
        settle();
        configure(7'd64, 7'd1, 1'b0, 1'b1);
        repeat (63) push_random();
        settle();
        configure(7'd64, 7'd1, 1'b1, 1'b0);
        repeat (4) push_random();
        send_item(OP_FINISH, '0, '0);
        settle();

        // The receiver holds off while the sender keeps offering pushes, so the
        // output queue fills and the input stalls.
        configure(7'd8, 7'd2, 1'b1, 1'b1);
        tx_gaps      = 1'b0;
        rx_gaps      = 1'b0;
        hold_off_req = 1'b1;
        repeat (20) push_random();
        settle();

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       flen = 7'd0;
                1:       flen = 7'd64;
                2:       flen = 7'd127;
                3:       flen = 7'($urandom_range(65, 127));
                4:       flen = 7'($urandom_range(13, 63));
                default: flen = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       hlen = 7'd0;
                1:       hlen = 7'd127;
                2:       hlen = flen;
                3:       hlen = 7'd1;
                default: hlen = 7'($urandom_range(1, 12));
            endcase
            wr_sel = $urandom_range(0, 2);
            configure(flen, hlen, wr_sel != 2, wr_sel != 1);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            burst   = $urandom_range(1, 30);
            repeat (burst) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(OP_FINISH, rand_sample(), rand_sample());
                end else begin
                    push_random();
                end
            end
            settle();
        end

        repeat (TAIL) @(posedge i_clk);
        if (outstanding != 0) begin
            $display("%0t: %0d predicted frame results never arrived", $time, outstanding);
        end
        $display("Sent %0d items (%0d pushes, %0d finishes) across %0d register settings,",
                 items_sent, pushes_sent, finishes_sent, settings_used);
        $display("with %0d results in %0d frames compared and %0d mismatches.",
                 results, frames, errors);
        if (errors == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ofb_pkg.sv
hw/rtl/ofb_smp_if.sv
hw/rtl/ofb_frm_if.sv
hw/rtl/ofb_lane.sv
hw/rtl/ofb_ctrl.sv
hw/rtl/ofb_merge.sv
hw/rtl/overlapping_frame_buffer.sv
hw/rtl/ofb_checker.sv
sim/overlapping_frame_buffer_checker.sv
sim/overlapping_frame_buffer_tb.sv
